// File: rtl/rpls_pkg.sv
// ----------------------------------------------------------------------------
// rpls_pkg
// Shared types, constants and helper functions for the recovery protocol
// level sequencer.
// ----------------------------------------------------------------------------
package rpls_pkg;

    // Widths and limits
    localparam int MAX_STEPS     = 32;
    localparam int COUNT_WIDTH   = 64;
    localparam int CFG_WIDTH     = 32;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int LEVEL_WIDTH   = 11;
    localparam int PULSE_WIDTH   = 16;
    localparam int TICK_WIDTH    = 32;
    localparam int STEP_WIDTH    = 6;

    localparam logic signed [PULSE_WIDTH-1:0] LEVEL_MAX = 16'sd1000;
    localparam logic signed [PULSE_WIDTH-1:0] LEVEL_MIN = -16'sd1000;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TICK_WIDTH-1:0]  tick_t;
    typedef logic [STEP_WIDTH-1:0]  step_t;
    typedef logic signed [LEVEL_WIDTH-1:0] level_t;

    // Phases of one step
    typedef enum logic [1:0] {
        PH_PAUSE    = 2'd0,
        PH_PULSE    = 2'd1,
        PH_RECOVERY = 2'd2,
        PH_PROBE    = 2'd3
    } phase_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_PAUSE_LEVEL    = 3'd0,
        REG_RECOVERY_LEVEL = 3'd1,
        REG_PULSE_LEVELS   = 3'd2,
        REG_PAUSE_TICKS    = 3'd3,
        REG_PULSE_TICKS    = 3'd4,
        REG_PROBE_TICKS    = 3'd5,
        REG_FIRST_RECOVERY = 3'd6,
        REG_STEP_COUNT     = 3'd7
    } reg_idx_t;

    // Register reset values
    localparam level_t RST_PAUSE_LEVEL    = '0;
    localparam level_t RST_RECOVERY_LEVEL = '0;
    localparam tick_t  RST_PULSE_LEVELS   = 32'd3276850;
    localparam tick_t  RST_PAUSE_TICKS    = 32'd200000;
    localparam tick_t  RST_PULSE_TICKS    = 32'd200000;
    localparam tick_t  RST_PROBE_TICKS    = 32'd50000;
    localparam tick_t  RST_FIRST_RECOVERY = 32'd500;
    localparam step_t  RST_STEP_COUNT     = 6'd10;

    typedef struct packed {
        level_t pause_level;
        level_t recovery_level;
        tick_t  pulse_levels;
        tick_t  pause_ticks;
        tick_t  pulse_ticks;
        tick_t  probe_ticks;
        tick_t  first_recovery;
        step_t  step_count;
    } cfg_t;

    typedef struct packed {
        level_t      level_mv;
        logic [1:0]  phase_code;
        step_t       step_index;
        logic        done;
    } result_t;

    // Clamp a level to +/-1000 mV
    function automatic level_t sat_level(input logic signed [PULSE_WIDTH-1:0] v);
        if (v > LEVEL_MAX)
            return LEVEL_WIDTH'(LEVEL_MAX);
        else if (v < LEVEL_MIN)
            return LEVEL_WIDTH'(LEVEL_MIN);
        else
            return v[LEVEL_WIDTH-1:0];
    endfunction

    // Phase length with zero read as one tick
    function automatic count_t len_min1(input count_t v);
        return (v == '0) ? count_t'(1) : v;
    endfunction

endpackage

// File: rtl/rpls_seq.sv
// ----------------------------------------------------------------------------
// rpls_seq
// Protocol state (phase, tick counter, step, recovery length, done) and the
// single-pass logic that turns one tick into one result.
// ----------------------------------------------------------------------------
module rpls_seq
    import rpls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  logic    restart,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t phase_reg, phase_next;
    count_t left_reg, left_next;
    step_t  step_reg, step_next;
    count_t rec_reg, rec_next;
    logic   fin_reg, fin_next;

    // state after an optional restart
    phase_t phase_e;
    count_t left_e;
    step_t  step_e;
    count_t rec_e;
    logic   fin_e;
    logic   fin_now;
    step_t  limit;
    step_t  step_inc;
    level_t level;

    localparam logic RST_FINISHED = (RST_STEP_COUNT == '0);

    // State registers, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PAUSE;
            left_reg  <= count_t'(RST_PAUSE_TICKS);
            step_reg  <= step_t'(1);
            rec_reg   <= count_t'(RST_FIRST_RECOVERY);
            fin_reg   <= RST_FINISHED;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            step_reg  <= step_next;
            rec_reg   <= rec_next;
            fin_reg   <= fin_next;
        end
    end

    // Step limit, capped at MAX_STEPS
    assign limit = (cfg.step_count > STEP_WIDTH'(MAX_STEPS)) ? STEP_WIDTH'(MAX_STEPS)
                                                             : cfg.step_count;
    assign step_inc = step_e + 1'b1;

    // Restart re-arms before the tick is handled
    always_comb
    begin
        if (restart)
        begin
            phase_e = PH_PAUSE;
            left_e  = len_min1(count_t'(cfg.pause_ticks));
            step_e  = step_t'(1);
            rec_e   = count_t'(cfg.first_recovery);
            fin_e   = (limit == '0);
        end
        else
        begin
            phase_e = phase_reg;
            left_e  = left_reg;
            step_e  = step_reg;
            rec_e   = rec_reg;
            fin_e   = fin_reg;
        end
    end

    assign fin_now = fin_e || (step_e > limit);

    // Level of the current phase
    always_comb
    begin
        unique case (phase_e)
            PH_PAUSE:    level = sat_level(PULSE_WIDTH'(cfg.pause_level));
            PH_PULSE:    level = sat_level(cfg.pulse_levels[PULSE_WIDTH-1:0]);
            PH_RECOVERY: level = sat_level(PULSE_WIDTH'(cfg.recovery_level));
            PH_PROBE:    level = sat_level(cfg.pulse_levels[TICK_WIDTH-1:PULSE_WIDTH]);
            default:     level = '0;
        endcase
    end

    // Result and next state
    always_comb
    begin
        phase_next = phase_e;
        left_next  = left_e;
        step_next  = step_e;
        rec_next   = rec_e;
        fin_next   = fin_now;

        res.step_index = step_e;
        if (fin_now)
        begin
            res.level_mv   = '0;
            res.phase_code = PH_PAUSE;
            res.done       = 1'b1;
        end
        else
        begin
            res.level_mv   = level;
            res.phase_code = phase_e;
            res.done       = 1'b0;

            if (left_e > count_t'(1))
            begin
                left_next = left_e - 1'b1;
            end
            else
            begin
                unique case (phase_e)
                    PH_PAUSE:
                    begin
                        phase_next = PH_PULSE;
                        left_next  = len_min1(count_t'(cfg.pulse_ticks));
                    end
                    PH_PULSE:
                    begin
                        phase_next = PH_RECOVERY;
                        left_next  = len_min1(rec_e);
                    end
                    PH_RECOVERY:
                    begin
                        phase_next = PH_PROBE;
                        left_next  = len_min1(count_t'(cfg.probe_ticks));
                    end
                    PH_PROBE:
                    begin
                        phase_next = PH_PAUSE;
                        left_next  = len_min1(count_t'(cfg.pause_ticks));
                        step_next  = step_inc;
                        // doubling saturates at all ones
                        rec_next   = rec_e[COUNT_WIDTH-1] ? '1
                                                          : {rec_e[COUNT_WIDTH-2:0], 1'b0};
                        fin_next   = (step_inc > limit);
                    end
                    default:
                    begin
                        phase_next = PH_PAUSE;
                    end
                endcase
            end
        end
    end

endmodule

// File: rtl/recovery_protocol_level_sequencer.sv
// ----------------------------------------------------------------------------
// recovery_protocol_level_sequencer
// Emits one clamp level per sample tick, walking pause, inactivating pulse,
// recovery and recovery pulse phases with a doubling recovery length.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  input    | in_valid / in_stall       | restart
//  output   | out_valid / out_stall     | level_mv, phase_code, step_index, done_res
//  config   | cfg_we                    | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; a result is registered in the
//  output register, or in the skid register while the output is stalled.
//  rpls_seq updates its state (a 64-bit tick decrement and compare) per accepted tick.
//  Reset loads the register defaults and arms the protocol at step one.
//  A two-entry output (register plus skid) still takes one tick after
//  out_stall rises; in_stall follows only once both are full.
// ----------------------------------------------------------------------------
module recovery_protocol_level_sequencer
    import rpls_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     restart,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [10:0]       level_mv,
    output logic [1:0]               phase_code,
    output logic [5:0]               step_index,
    output logic                     done_res,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    result_t res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause_level    <= RST_PAUSE_LEVEL;
            cfg_reg.recovery_level <= RST_RECOVERY_LEVEL;
            cfg_reg.pulse_levels   <= RST_PULSE_LEVELS;
            cfg_reg.pause_ticks    <= RST_PAUSE_TICKS;
            cfg_reg.pulse_ticks    <= RST_PULSE_TICKS;
            cfg_reg.probe_ticks    <= RST_PROBE_TICKS;
            cfg_reg.first_recovery <= RST_FIRST_RECOVERY;
            cfg_reg.step_count     <= RST_STEP_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PAUSE_LEVEL:    cfg_reg.pause_level    <= cfg_data[LEVEL_WIDTH-1:0];
                REG_RECOVERY_LEVEL: cfg_reg.recovery_level <= cfg_data[LEVEL_WIDTH-1:0];
                REG_PULSE_LEVELS:   cfg_reg.pulse_levels   <= cfg_data;
                REG_PAUSE_TICKS:    cfg_reg.pause_ticks    <= cfg_data;
                REG_PULSE_TICKS:    cfg_reg.pulse_ticks    <= cfg_data;
                REG_PROBE_TICKS:    cfg_reg.probe_ticks    <= cfg_data;
                REG_FIRST_RECOVERY: cfg_reg.first_recovery <= cfg_data;
                REG_STEP_COUNT:     cfg_reg.step_count     <= cfg_data[STEP_WIDTH-1:0];
                default:            cfg_reg.step_count     <= cfg_reg.step_count;
            endcase
        end
    end

    // Handshake
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    rpls_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .restart (restart),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign level_mv   = out_reg.level_mv;
    assign phase_code = out_reg.phase_code;
    assign step_index = out_reg.step_index;
    assign done_res   = out_reg.done;

    // Checks
    a_done_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (level_mv == '0 && phase_code == PH_PAUSE))
        else $error("done result with nonzero level or phase");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid holds an item while output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall && !out_stall) |=> !in_stall)
        else $error("skid did not drain when output was taken");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step_index != '0))
        else $error("result with step index zero");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recovery protocol level sequencer. A small
// scoreboard predicts the level, phase, step and done flag of every accepted
// tick and checks each result against them in order. Directed settings cover
// level saturation, zero-length phases, zero and oversized step counts and
// huge phase lengths. Random settings, restarts and idling on both sides
// follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import rpls_pkg::*;
();

    localparam int TICK_TARGET = 700;
    localparam int QUIET_LIMIT = 1000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     restart;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [10:0]       level_mv;
    logic [1:0]               phase_code;
    logic [5:0]               step_index;
    logic                     done_res;
    logic                     cfg_we;
    logic [CFG_IDX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]     cfg_data;

    // Scoreboard: its own copy of the registers and the sequencer state
    class clamp_level_board;
        level_t      pause_lvl;
        level_t      rec_lvl;
        tick_t       pulse_lvls;
        tick_t       pause_len;
        tick_t       pulse_len;
        tick_t       probe_len;
        tick_t       first_rec;
        step_t       steps;

        phase_t      ph;
        count_t      left;
        int unsigned step_no;
        count_t      rec_len;
        bit          finished;

        result_t     levels_due[$];
        int unsigned mismatches;
        int unsigned ticks_seen;
        int unsigned results_seen;
        int unsigned restarts_seen;
        int unsigned done_seen;
        bit [3:0]    phases_seen;

        function new();
            pause_lvl  = RST_PAUSE_LEVEL;
            rec_lvl    = RST_RECOVERY_LEVEL;
            pulse_lvls = RST_PULSE_LEVELS;
            pause_len  = RST_PAUSE_TICKS;
            pulse_len  = RST_PULSE_TICKS;
            probe_len  = RST_PROBE_TICKS;
            first_rec  = RST_FIRST_RECOVERY;
            steps      = RST_STEP_COUNT;
            rearm();
        endfunction

        function int unsigned step_cap();
            return (steps > MAX_STEPS) ? MAX_STEPS : steps;
        endfunction

        function count_t at_least_one(count_t v);
            return (v == 0) ? count_t'(1) : v;
        endfunction

        function void rearm();
            ph       = PH_PAUSE;
            left     = at_least_one(count_t'(pause_len));
            step_no  = 1;
            rec_len  = count_t'(first_rec);
            finished = (step_no > step_cap());
        endfunction

        function void set_reg(reg_idx_t idx, tick_t val);
            case (idx)
                REG_PAUSE_LEVEL:    pause_lvl  = val[10:0];
                REG_RECOVERY_LEVEL: rec_lvl    = val[10:0];
                REG_PULSE_LEVELS:   pulse_lvls = val;
                REG_PAUSE_TICKS:    pause_len  = val;
                REG_PULSE_TICKS:    pulse_len  = val;
                REG_PROBE_TICKS:    probe_len  = val;
                REG_FIRST_RECOVERY: first_rec  = val;
                default:            steps      = val[5:0];
            endcase
        endfunction

        // Level of the current phase, then the phase/step advance
        function void note_tick(bit rs);
            result_t            r;
            logic signed [15:0] raw;
            int                 v;
            ticks_seen++;
            if (rs) begin
                restarts_seen++;
                rearm();
            end
            if (step_no > step_cap())
                finished = 1'b1;
            r.step_index = 6'(step_no);
            if (finished) begin
                r.level_mv   = '0;
                r.phase_code = PH_PAUSE;
                r.done       = 1'b1;
            end
            else begin
                case (ph)
                    PH_PAUSE:    raw = pause_lvl;
                    PH_PULSE:    raw = pulse_lvls[15:0];
                    PH_RECOVERY: raw = rec_lvl;
                    default:     raw = pulse_lvls[31:16];
                endcase
                v = raw;
                if (v > 1000)
                    v = 1000;
                else if (v < -1000)
                    v = -1000;
                r.level_mv   = v[10:0];
                r.phase_code = ph;
                r.done       = 1'b0;
                phases_seen[ph] = 1'b1;
                if (left > 1)
                    left--;
                else begin
                    case (ph)
                        PH_PAUSE:
                        begin
                            ph   = PH_PULSE;
                            left = at_least_one(count_t'(pulse_len));
                        end
                        PH_PULSE:
                        begin
                            ph   = PH_RECOVERY;
                            left = at_least_one(rec_len);
                        end
                        PH_RECOVERY:
                        begin
                            ph   = PH_PROBE;
                            left = at_least_one(count_t'(probe_len));
                        end
                        default:
                        begin
                            ph   = PH_PAUSE;
                            left = at_least_one(count_t'(pause_len));
                            step_no++;
                            // doubling saturates at all ones
                            rec_len = rec_len[COUNT_WIDTH-1] ? '1 : (rec_len << 1);
                            if (step_no > step_cap())
                                finished = 1'b1;
                        end
                    endcase
                end
            end
            levels_due.push_back(r);
        endfunction

        function void check_level(result_t got);
            result_t want;
            results_seen++;
            if (got.done)
                done_seen++;
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: lvl=%0d ph=%0d step=%0d done=%0b",
                             results_seen, got.level_mv, got.phase_code,
                             got.step_index, got.done);
                return;
            end
            want = levels_due.pop_front();
            if (got.level_mv !== want.level_mv || got.phase_code !== want.phase_code ||
                got.step_index !== want.step_index || got.done !== want.done) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at result %0d: expected lvl=%0d ph=%0d step=%0d done=%0b",
                             results_seen, want.level_mv, want.phase_code,
                             want.step_index, want.done);
                    $display("    got lvl=%0d ph=%0d step=%0d done=%0b",
                             got.level_mv, got.phase_code, got.step_index, got.done);
                end
            end
        endfunction
    endclass

    clamp_level_board board = new();
    int unsigned      quiet_cycles;
    int unsigned      settings_run;

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    recovery_protocol_level_sequencer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .level_mv   (level_mv),
        .phase_code (phase_code),
        .step_index (step_index),
        .done_res   (done_res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: check, random stalls, one long hold-off
    initial
    begin
        result_t got;
        int      hold_left;
        bit      held;
        bit      calm;
        hold_left = 0;
        held      = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.level_mv   = level_mv;
                got.phase_code = phase_code;
                got.step_index = step_index;
                got.done       = done_res;
                board.check_level(got);
            end
            if (!held && board.results_seen >= 300) begin
                held      = 1'b1;
                hold_left = 80;
            end
            calm = (board.results_seen >= 400 && board.results_seen < 550);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    task automatic write_reg(input reg_idx_t idx, input tick_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    // Writes the registers picked by mask; level registers get junk upper bits
    task automatic load_setting(input cfg_t s, input bit [7:0] mask);
        reg_idx_t idx;
        tick_t    data;
        for (int i = 0; i < 8; i++) begin
            if (mask[i]) begin
                idx = reg_idx_t'(i);
                case (idx)
                    REG_PAUSE_LEVEL:    data = {21'($urandom), s.pause_level};
                    REG_RECOVERY_LEVEL: data = {21'($urandom), s.recovery_level};
                    REG_PULSE_LEVELS:   data = s.pulse_levels;
                    REG_PAUSE_TICKS:    data = s.pause_ticks;
                    REG_PULSE_TICKS:    data = s.pulse_ticks;
                    REG_PROBE_TICKS:    data = s.probe_ticks;
                    REG_FIRST_RECOVERY: data = s.first_recovery;
                    default:            data = {26'($urandom), s.step_count};
                endcase
                write_reg(idx, data);
            end
        end
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // One tick item: random idle gaps, then hold until taken
    task automatic send_tick(input bit rs);
        bit calm;
        calm = (board.ticks_seen >= 400 && board.ticks_seen < 550);
        while (!calm && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_tick(rs);
    endtask

    task automatic wait_drained();
        while (board.levels_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic run_ticks(input int n, input bit first_rs, input int rs_pct);
        for (int i = 0; i < n; i++)
            send_tick((i == 0) ? first_rs : ($urandom_range(0, 99) < rs_pct));
        in_valid <= 1'b0;
        wait_drained();
    endtask

    function automatic cfg_t make_setting(level_t pl, level_t rl, tick_t pv, tick_t pt,
                                          tick_t ut, tick_t bt, tick_t fr, step_t sc);
        cfg_t s;
        s.pause_level    = pl;
        s.recovery_level = rl;
        s.pulse_levels   = pv;
        s.pause_ticks    = pt;
        s.pulse_ticks    = ut;
        s.probe_ticks    = bt;
        s.first_recovery = fr;
        s.step_count     = sc;
        return s;
    endfunction

    function automatic level_t rand_level();
        if ($urandom_range(0, 1))
            return level_t'($urandom);
        return level_t'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic logic [15:0] rand_pulse();
        if ($urandom_range(0, 1))
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    // Mostly short phases so steps progress; now and then a huge one
    function automatic tick_t rand_len(input int short_max);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return $urandom_range(0, short_max);
        if (pick < 95)
            return $urandom_range(short_max + 1, 40);
        return $urandom;
    endfunction

    function automatic step_t rand_steps();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return step_t'($urandom_range(0, 5));
        if (pick < 17)
            return step_t'($urandom_range(6, 10));
        return step_t'($urandom_range(30, 63));
    endfunction

    // Stimulus
    initial
    begin
        cfg_t s;
        settings_run = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_PAUSE_LEVEL;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults straight out of reset
        run_ticks(3, 1'b0, 0);

        // out-of-range levels saturate; zero-length pause; two steps to done
        s = make_setting(level_t'(11'h400), level_t'(11'h3FF), {16'h8000, 16'h7FFF},
                         0, 1, 2, 1, 6'd2);
        load_setting(s, 8'hFF);
        run_ticks(13, 1'b1, 0);

        // zero steps: done from the first tick
        s = make_setting(-11'sd1000, 11'sd1000, {16'd1000, 16'hFC18}, 1, 1, 1, 1, 6'd0);
        load_setting(s, 8'hFF);
        run_ticks(3, 1'b1, 0);

        // largest lengths and the full step count
        s = make_setting(level_t'(11'h7FF), 11'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32);
        load_setting(s, 8'hFF);
        run_ticks(4, 1'b1, 0);

        // step count above the maximum runs 32 steps of one-tick phases to done
        s = make_setting(11'sd1000, -11'sd1000, {16'hFC18, 16'd1000}, 1, 0, 1, 0, 6'd63);
        load_setting(s, 8'hFF);
        run_ticks(135, 1'b1, 0);

        // random settings, some applied mid-run without a restart
        while (board.ticks_seen < TICK_TARGET) begin
            s = make_setting(rand_level(), rand_level(), {rand_pulse(), rand_pulse()},
                             rand_len(3), rand_len(3), rand_len(3), rand_len(2),
                             rand_steps());
            load_setting(s, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
            run_ticks($urandom_range(15, 60), $urandom_range(0, 9) < 7, 3);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Run covered %0d ticks over %0d register settings, %0d restarts.",
                 board.ticks_seen, settings_run, board.restarts_seen);
        $display("Results checked: %0d, of which %0d done; phases seen mask %b.",
                 board.results_seen, board.done_seen, board.phases_seen);
        if (board.mismatches == 0 && board.levels_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
